// ----- hw/rtl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared types, character codes, status codes and constants for the
// reverse Polish evaluator and its iterative arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int QW = 48;
  localparam int DW = 50;
  localparam int FB = 16;

  localparam logic [QW-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 48'h8000_0000_0000;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_DIV_ZERO  = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_DISPATCH,
    S_RD_B,
    S_EXEC,
    S_ALU,
    S_RD_TOP,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_RUN,
    A_ROUND,
    A_SAT,
    A_DONE
  } alu_state_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic          start;
    alu_op_e       op;
    logic          neg;
    logic [QW-1:0] opa;
    logic [DW-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] value;
  } alu_rsp_t;

  function automatic logic [DW-1:0] pow10(input logic [3:0] idx);
    logic [DW-1:0] r;
    case (idx)
      4'd0:  r = 50'd1;
      4'd1:  r = 50'd10;
      4'd2:  r = 50'd100;
      4'd3:  r = 50'd1000;
      4'd4:  r = 50'd10000;
      4'd5:  r = 50'd100000;
      4'd6:  r = 50'd1000000;
      4'd7:  r = 50'd10000000;
      4'd8:  r = 50'd100000000;
      4'd9:  r = 50'd1000000000;
      4'd10: r = 50'd10000000000;
      4'd11: r = 50'd100000000000;
      4'd12: r = 50'd1000000000000;
      4'd13: r = 50'd10000000000000;
      4'd14: r = 50'd100000000000000;
      4'd15: r = 50'd1000000000000000;
      default: r = 50'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/rpn_ram.sv -----
// ----------------------------------------------------------------------------
// RPN generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rpn_alu.sv -----
// ----------------------------------------------------------------------------
// RPN iterative arithmetic unit
// One shared adder/subtractor runs a shift-add multiply or a restoring
// divide one bit per cycle, then rounds and saturates to signed Q31.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t rsp_o
);

  localparam int QW = rpn_pkg::QW;
  localparam int DW = rpn_pkg::DW;
  localparam int FB = rpn_pkg::FB;
  localparam int NW = QW + FB;
  localparam int MUL_STEPS = QW;
  localparam int DIV_STEPS = NW;
  localparam int CW = $clog2(DIV_STEPS);

  rpn_pkg::alu_state_e state_q, state_d;
  rpn_pkg::alu_op_e    op_q, op_d;
  logic                neg_q, neg_d;
  logic [QW-1:0]       ma_q, ma_d;
  logic [DW-1:0]       den_q, den_d;
  logic [2*QW-1:0]     p_q, p_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                rnd_q, rnd_d;
  logic [QW-1:0]       res_q, res_d;

  logic [DW:0]   add_x;
  logic [DW:0]   add_y;
  logic          add_sub;
  logic [DW+1:0] add_w;
  logic          carry;

  logic [NW-1:0] q_src;
  logic [NW:0]   q_w;
  logic          ovf;
  logic [QW-1:0] mag;
  logic [QW-1:0] sat_val;

  always_comb begin
    if (state_q == rpn_pkg::A_ROUND) begin
      add_x   = {rem_q, 1'b0};
      add_y   = {1'b0, den_q};
      add_sub = 1'b1;
    end else if (op_q == rpn_pkg::ALU_DIV) begin
      add_x   = {rem_q, p_q[NW-1]};
      add_y   = {1'b0, den_q};
      add_sub = 1'b1;
    end else begin
      add_x   = (DW+1)'(p_q[2*QW-1:QW]);
      add_y   = p_q[0] ? (DW+1)'(ma_q) : '0;
      add_sub = 1'b0;
    end
  end

  assign add_w = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (DW+2)'(add_sub);
  assign carry = add_w[DW+1];

  assign q_src   = (op_q == rpn_pkg::ALU_DIV) ? p_q[NW-1:0] : NW'(p_q[NW-1:FB]);
  assign q_w     = {1'b0, q_src} + (NW+1)'(rnd_q);
  assign ovf     = (|q_w[NW:QW]) || ((op_q == rpn_pkg::ALU_MUL) && (|p_q[2*QW-1:NW]));
  assign mag     = q_w[QW-1:0];
  assign sat_val = (ovf || mag[QW-1]) ? (neg_q ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                                      : (neg_q ? (~mag + QW'(1)) : mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    ma_q  <= ma_d;
    den_q <= den_d;
    p_q   <= p_d;
    rem_q <= rem_d;
    rnd_q <= rnd_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    neg_d   = neg_q;
    ma_d    = ma_q;
    den_d   = den_q;
    p_d     = p_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    res_d   = res_q;
    case (state_q)
      rpn_pkg::A_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          neg_d   = req_i.neg;
          state_d = rpn_pkg::A_RUN;
          if (req_i.op == rpn_pkg::ALU_DIV) begin
            p_d   = (2*QW)'({req_i.opa, FB'(0)});
            rem_d = '0;
            den_d = req_i.opb;
            cnt_d = CW'(DIV_STEPS - 1);
          end else begin
            p_d   = (2*QW)'(req_i.opb[QW-1:0]);
            ma_d  = req_i.opa;
            cnt_d = CW'(MUL_STEPS - 1);
          end
        end
      end
      rpn_pkg::A_RUN: begin
        if (op_q == rpn_pkg::ALU_DIV) begin
          rem_d          = carry ? add_w[DW-1:0] : add_x[DW-1:0];
          p_d[NW-1:0]    = {p_q[NW-2:0], carry};
        end else begin
          p_d = {add_w[QW:0], p_q[QW-1:1]};
        end
        if (cnt_q == '0) begin
          state_d = rpn_pkg::A_ROUND;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      rpn_pkg::A_ROUND: begin
        rnd_d   = (op_q == rpn_pkg::ALU_DIV) ? carry : p_q[FB-1];
        state_d = rpn_pkg::A_SAT;
      end
      rpn_pkg::A_SAT: begin
        res_d   = sat_val;
        state_d = rpn_pkg::A_DONE;
      end
      rpn_pkg::A_DONE: begin
        state_d = rpn_pkg::A_IDLE;
      end
      default: begin
        state_d = rpn_pkg::A_IDLE;
      end
    endcase
  end

  assign rsp_o.done  = (state_q == rpn_pkg::A_DONE);
  assign rsp_o.value = res_q;

endmodule

// ----- hw/rtl/rpn_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// RPN expression evaluator
// Evaluates reverse Polish text, one ASCII character per transaction, on an
// operand stack in signed Q31.16 fixed point.
// A digit or point is taken in S_IDLE; any other character goes on through
// S_DISPATCH, and ending a pending number first runs the shared unit (64 divide
// steps) in S_CONV. '*' and '/' also wait on the shared unit in S_ALU.
// A '#' passes S_DISPATCH, S_RD_TOP and S_EMIT before its result is
// registered, and a stalled result holds the input. Reset clears the stack
// pointer, number and error state; the stack RAM is left as is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_expression_evaluator #(
  parameter int STACK_DEPTH     = 32,
  parameter int MAX_TOKEN_CHARS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] value_o,
  output logic [2:0]         status_o
);

  localparam int QW  = rpn_pkg::QW;
  localparam int DW  = rpn_pkg::DW;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int TLW = $clog2(MAX_TOKEN_CHARS);

  rpn_pkg::ctrl_state_e state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [31:0]    mant_q, mant_d;
  logic [3:0]     frac_q, frac_d;
  logic [TLW-1:0] tlen_q, tlen_d;
  logic           in_num_q, in_num_d;
  logic           seen_pt_q, seen_pt_d;
  logic           skip_q, skip_d;
  logic [7:0]     char_q, char_d;
  logic [QW-1:0]  b_q, b_d;
  logic [QW-1:0]  em_val_q, em_val_d;
  logic [2:0]     em_st_q, em_st_d;
  logic           out_valid_q;
  logic [QW-1:0]  value_q;
  logic [2:0]     status_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [QW-1:0]  ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [QW-1:0]  ram_rdata;

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;

  logic           accept;
  logic           out_load;
  logic           is_digit;
  logic           is_point;
  logic           is_op_q;
  logic [TLW:0]   tlen_inc;
  logic           too_long;
  logic [35:0]    m10;
  logic [SPW-1:0] sp_m1;
  logic [SPW-1:0] sp_m2;
  logic           sp_full;
  logic [QW-1:0]  a_val;
  logic [QW-1:0]  a_mag;
  logic [QW-1:0]  b_mag;
  logic [QW:0]    addsub_w;
  logic [QW-1:0]  addsub_sat;
  logic           err;
  logic [2:0]     err_code;
  logic           err_hash;
  logic           clr;

  rpn_ram #(
    .WIDTH(QW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rpn_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o = (state_q != rpn_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == rpn_pkg::S_EMIT) && (!out_valid_q || !out_stall_i);

  assign is_digit = (in_char_i >= rpn_pkg::CH_ZERO) && (in_char_i <= rpn_pkg::CH_NINE);
  assign is_point = (in_char_i == rpn_pkg::CH_POINT);
  assign is_op_q  = (char_q == rpn_pkg::CH_PLUS) || (char_q == rpn_pkg::CH_MINUS) ||
                    (char_q == rpn_pkg::CH_STAR) || (char_q == rpn_pkg::CH_SLASH);

  assign tlen_inc = {1'b0, tlen_q} + (TLW+1)'(1);
  assign too_long = (tlen_inc >= (TLW+1)'(MAX_TOKEN_CHARS));
  assign m10      = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + 36'(in_char_i[3:0]);

  assign sp_m1   = sp_q - SPW'(1);
  assign sp_m2   = sp_q - SPW'(2);
  assign sp_full = (sp_q >= SPW'(STACK_DEPTH));

  assign a_val = ram_rdata;
  assign a_mag = a_val[QW-1] ? (~a_val + QW'(1)) : a_val;
  assign b_mag = b_q[QW-1] ? (~b_q + QW'(1)) : b_q;

  assign addsub_w   = (char_q == rpn_pkg::CH_MINUS) ? ({a_val[QW-1], a_val} - {b_q[QW-1], b_q})
                                                    : ({a_val[QW-1], a_val} + {b_q[QW-1], b_q});
  assign addsub_sat = (addsub_w[QW] != addsub_w[QW-1])
                    ? (addsub_w[QW] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX) : addsub_w[QW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::S_IDLE;
      sp_q        <= '0;
      mant_q      <= '0;
      frac_q      <= '0;
      tlen_q      <= '0;
      in_num_q    <= 1'b0;
      seen_pt_q   <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      mant_q      <= mant_d;
      frac_q      <= frac_d;
      tlen_q      <= tlen_d;
      in_num_q    <= in_num_d;
      seen_pt_q   <= seen_pt_d;
      skip_q      <= skip_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    b_q      <= b_d;
    em_val_q <= em_val_d;
    em_st_q  <= em_st_d;
    if (out_load) begin
      value_q  <= em_val_q;
      status_q <= em_st_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    mant_d    = mant_q;
    frac_d    = frac_q;
    tlen_d    = tlen_q;
    in_num_d  = in_num_q;
    seen_pt_d = seen_pt_q;
    skip_d    = skip_q;
    char_d    = char_q;
    b_d       = b_q;
    em_val_d  = em_val_q;
    em_st_d   = em_st_q;
    ram_we    = 1'b0;
    ram_waddr = sp_m2[AW-1:0];
    ram_wdata = addsub_sat;
    ram_re    = 1'b0;
    ram_raddr = sp_m1[AW-1:0];
    alu_req   = '0;
    err       = 1'b0;
    err_code  = rpn_pkg::STAT_OK;
    err_hash  = 1'b0;
    clr       = 1'b0;

    case (state_q)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          if (skip_q) begin
            clr = (in_char_i == rpn_pkg::CH_HASH);
          end else if (is_digit || is_point) begin
            if (too_long) begin
              err      = 1'b1;
              err_code = rpn_pkg::STAT_TOO_LONG;
            end else begin
              tlen_d   = tlen_inc[TLW-1:0];
              in_num_d = 1'b1;
              if (is_point) begin
                seen_pt_d = 1'b1;
              end else begin
                mant_d = (|m10[35:32]) ? 32'hFFFF_FFFF : m10[31:0];
                if (seen_pt_q && (frac_q != 4'hF)) begin
                  frac_d = frac_q + 4'd1;
                end
              end
            end
          end else begin
            char_d = in_char_i;
            if (in_num_q) begin
              alu_req.start = 1'b1;
              alu_req.op    = rpn_pkg::ALU_DIV;
              alu_req.neg   = 1'b0;
              alu_req.opa   = QW'(mant_q);
              alu_req.opb   = rpn_pkg::pow10(frac_q);
              mant_d        = '0;
              frac_d        = '0;
              tlen_d        = '0;
              in_num_d      = 1'b0;
              seen_pt_d     = 1'b0;
              state_d       = rpn_pkg::S_CONV;
            end else begin
              state_d = rpn_pkg::S_DISPATCH;
            end
          end
        end
      end
      rpn_pkg::S_CONV: begin
        if (alu_rsp.done) begin
          if (sp_full) begin
            err      = 1'b1;
            err_code = rpn_pkg::STAT_OVERFLOW;
            err_hash = (char_q == rpn_pkg::CH_HASH);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = sp_q[AW-1:0];
            ram_wdata = alu_rsp.value;
            sp_d      = sp_q + SPW'(1);
            state_d   = rpn_pkg::S_DISPATCH;
          end
        end
      end
      rpn_pkg::S_DISPATCH: begin
        if (is_op_q) begin
          if (sp_q < SPW'(2)) begin
            err      = 1'b1;
            err_code = rpn_pkg::STAT_UNDERFLOW;
          end else begin
            ram_re  = 1'b1;
            state_d = rpn_pkg::S_RD_B;
          end
        end else if (char_q == rpn_pkg::CH_HASH) begin
          if (sp_q == '0) begin
            err      = 1'b1;
            err_code = rpn_pkg::STAT_UNDERFLOW;
            err_hash = 1'b1;
          end else begin
            ram_re  = 1'b1;
            state_d = rpn_pkg::S_RD_TOP;
          end
        end else begin
          state_d = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_RD_B: begin
        b_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = sp_m2[AW-1:0];
        state_d   = rpn_pkg::S_EXEC;
      end
      rpn_pkg::S_EXEC: begin
        if ((char_q == rpn_pkg::CH_SLASH) && (b_q == '0)) begin
          err      = 1'b1;
          err_code = rpn_pkg::STAT_DIV_ZERO;
        end else if ((char_q == rpn_pkg::CH_PLUS) || (char_q == rpn_pkg::CH_MINUS)) begin
          ram_we  = 1'b1;
          sp_d    = sp_m1;
          state_d = rpn_pkg::S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = (char_q == rpn_pkg::CH_STAR) ? rpn_pkg::ALU_MUL : rpn_pkg::ALU_DIV;
          alu_req.neg   = a_val[QW-1] ^ b_q[QW-1];
          alu_req.opa   = a_mag;
          alu_req.opb   = DW'(b_mag);
          state_d       = rpn_pkg::S_ALU;
        end
      end
      rpn_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = alu_rsp.value;
          sp_d      = sp_m1;
          state_d   = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_RD_TOP: begin
        em_val_d = ram_rdata;
        em_st_d  = rpn_pkg::STAT_OK;
        clr      = 1'b1;
        state_d  = rpn_pkg::S_EMIT;
      end
      rpn_pkg::S_EMIT: begin
        if (out_load) begin
          state_d = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rpn_pkg::S_IDLE;
      end
    endcase

    // An error reports at once; a '#' that fails also clears the block.
    if (err) begin
      em_val_d = '0;
      em_st_d  = err_code;
      state_d  = rpn_pkg::S_EMIT;
      if (err_hash) begin
        clr = 1'b1;
      end else begin
        skip_d = 1'b1;
      end
    end

    if (clr) begin
      sp_d      = '0;
      mant_d    = '0;
      frac_d    = '0;
      tlen_d    = '0;
      in_num_d  = 1'b0;
      seen_pt_d = 1'b0;
      skip_d    = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != rpn_pkg::STAT_OK)) |-> (value_q == '0))
    else $error("error transaction carries a nonzero value");

  a_sp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_alu_done_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> ((state_q == rpn_pkg::S_CONV) || (state_q == rpn_pkg::S_ALU)))
    else $error("arithmetic unit finished while the sequencer was not waiting");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rpn_pkg::S_EMIT))
    else $error("output transaction raised outside the emit state");

endmodule

// ----- sim/rpn_expression_evaluator_checker.sv -----
// ----------------------------------------------------------------------------
// RPN evaluator checker
// Watches the character and result channels of the evaluator, runs its own
// Q31.16 stack machine on every accepted character, and compares each
// accepted result field by field with the oldest result still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_expression_evaluator_checker #(
  parameter int STACK_DEPTH     = 32,
  parameter int MAX_TOKEN_CHARS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         in_char_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [47:0] value_i,
  input  logic [2:0]         status_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  localparam logic signed [63:0] WIDE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] WIDE_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [47:0] value;
    logic [2:0]         status;
  } outcome_t;

  outcome_t           results_due[$];
  logic signed [47:0] stack_q[STACK_DEPTH];
  int unsigned        depth_q     = 0;
  logic [31:0]        mant_q      = '0;
  int unsigned        frac_q      = 0;
  int unsigned        len_q       = 0;
  bit                 in_number_q = 1'b0;
  bit                 point_q     = 1'b0;
  bit                 skipping_q  = 1'b0;

  function automatic logic [63:0] magnitude(input logic signed [47:0] v);
    logic signed [63:0] w;
    w = v;
    if (w < 0) w = -w;
    return w;
  endfunction

  function automatic logic signed [47:0] clamp_mag(input bit neg, input logic [63:0] mag);
    logic [63:0] twos;
    twos = ~mag + 64'd1;
    if (neg) return (mag >= 64'h0000_8000_0000_0000) ? rpn_pkg::Q_MIN : twos[47:0];
    return (mag > 64'h0000_7FFF_FFFF_FFFF) ? rpn_pkg::Q_MAX : mag[47:0];
  endfunction

  function automatic logic signed [47:0] fx_add(input logic signed [47:0] a,
                                                input logic signed [47:0] b,
                                                input bit subtract);
    logic signed [63:0] sa, sb, s;
    sa = a;
    sb = b;
    s = subtract ? sa - sb : sa + sb;
    if (s > WIDE_MAX) return rpn_pkg::Q_MAX;
    if (s < WIDE_MIN) return rpn_pkg::Q_MIN;
    return s[47:0];
  endfunction

  function automatic logic signed [47:0] fx_mul(input logic signed [47:0] a,
                                                input logic signed [47:0] b);
    logic [127:0] ma, mb, prod;
    logic [63:0]  r;
    ma = magnitude(a);
    mb = magnitude(b);
    prod = ma * mb;
    if (prod[127:64] != 0) r = 64'h0001_0000_0000_0000;
    else r = {16'd0, prod[63:16]} + {63'd0, prod[15]};
    return clamp_mag(a[47] ^ b[47], r);
  endfunction

  function automatic logic signed [47:0] fx_div(input logic signed [47:0] a,
                                                input logic signed [47:0] b);
    logic [63:0] num, den, q, rem;
    num = magnitude(a) << 16;
    den = magnitude(b);
    q = num / den;
    rem = num % den;
    if ((rem << 1) >= den) q = q + 64'd1;
    return clamp_mag(a[47] ^ b[47], q);
  endfunction

  task automatic clear_predictor();
    depth_q = 0;
    mant_q = '0;
    frac_q = 0;
    len_q = 0;
    in_number_q = 1'b0;
    point_q = 1'b0;
    skipping_q = 1'b0;
  endtask

  task automatic raise_error(input logic [2:0] code, input logic [7:0] c);
    results_due.push_back('{value: 48'sd0, status: code});
    if (c == rpn_pkg::CH_HASH) clear_predictor();
    else skipping_q = 1'b1;
  endtask

  task automatic close_number(output logic [2:0] code);
    logic [63:0] scale, scaled;
    code = rpn_pkg::STAT_OK;
    if (!in_number_q) return;
    scale = 64'd1;
    repeat (frac_q) scale = scale * 64'd10;
    scaled = (({32'd0, mant_q} << 16) + (scale >> 1)) / scale;
    mant_q = '0;
    frac_q = 0;
    len_q = 0;
    in_number_q = 1'b0;
    point_q = 1'b0;
    if (depth_q >= STACK_DEPTH) begin
      code = rpn_pkg::STAT_OVERFLOW;
    end else begin
      stack_q[depth_q] = clamp_mag(1'b0, scaled);
      depth_q++;
    end
  endtask

  task automatic evaluate_char(input logic [7:0] c);
    logic [2:0]         code;
    logic [63:0]        widened;
    logic signed [47:0] lhs, rhs, res;
    if (skipping_q) begin
      if (c == rpn_pkg::CH_HASH) clear_predictor();
      return;
    end
    if ((c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) || c == rpn_pkg::CH_POINT) begin
      if (len_q + 1 >= MAX_TOKEN_CHARS) begin
        raise_error(rpn_pkg::STAT_TOO_LONG, c);
        return;
      end
      len_q++;
      in_number_q = 1'b1;
      if (c == rpn_pkg::CH_POINT) begin
        point_q = 1'b1;
      end else begin
        widened = mant_q * 64'd10 + (c - rpn_pkg::CH_ZERO);
        mant_q = (widened > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : widened[31:0];
        if (point_q && frac_q < 15) frac_q++;
      end
      return;
    end
    close_number(code);
    if (code != rpn_pkg::STAT_OK) begin
      raise_error(code, c);
      return;
    end
    if (c inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS, rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH})
    begin
      if (depth_q < 2) begin
        raise_error(rpn_pkg::STAT_UNDERFLOW, c);
        return;
      end
      rhs = stack_q[depth_q - 1];
      lhs = stack_q[depth_q - 2];
      if (c == rpn_pkg::CH_SLASH && rhs == 0) begin
        raise_error(rpn_pkg::STAT_DIV_ZERO, c);
        return;
      end
      case (c)
        rpn_pkg::CH_PLUS:  res = fx_add(lhs, rhs, 1'b0);
        rpn_pkg::CH_MINUS: res = fx_add(lhs, rhs, 1'b1);
        rpn_pkg::CH_STAR:  res = fx_mul(lhs, rhs);
        default:           res = fx_div(lhs, rhs);
      endcase
      stack_q[depth_q - 2] = res;
      depth_q--;
    end else if (c == rpn_pkg::CH_HASH) begin
      if (depth_q == 0) begin
        raise_error(rpn_pkg::STAT_UNDERFLOW, c);
      end else begin
        results_due.push_back('{value: stack_q[depth_q - 1], status: rpn_pkg::STAT_OK});
        clear_predictor();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches_o++;
  endtask

  task automatic check_result(input logic signed [47:0] got_value,
                              input logic [2:0] got_status);
    outcome_t want;
    if (results_due.size() == 0) begin
      report_mismatch("unexpected result", got_value, 0);
      return;
    end
    want = results_due.pop_front();
    if (got_value !== want.value) report_mismatch("value", got_value, want.value);
    if (got_status !== want.status) report_mismatch("status", got_status, want.status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_predictor();
    end else begin
      if (in_valid_i && !in_stall_i) evaluate_char(in_char_i);
      if (out_valid_i && !out_stall_i) check_result(value_i, status_i);
      pending_o = results_due.size();
    end
  end

endmodule

// ----- sim/rpn_expression_evaluator_test.sv -----
// ----------------------------------------------------------------------------
// RPN evaluator testbench
// Feeds the evaluator directed expressions and then random reverse Polish
// text, most of it well formed, some of it broken or noise, with random
// gaps on both channels, a long hold on the result side and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_expression_evaluator_test;

  localparam int         CLK_PERIOD      = 10;
  localparam int         STACK_DEPTH     = 32;
  localparam int         MAX_TOKEN_CHARS = 10;
  localparam int         RANDOM_CHARS    = 700;
  localparam int         RX_HOLD_CYCLES  = 3000;
  localparam int         SETTLE_CYCLES   = 400;
  localparam logic [7:0] CH_SPACE        = 8'h20;
  localparam logic [7:0] CH_TAB          = 8'h09;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [7:0]         in_char   = 8'h00;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [47:0] value;
  logic [2:0]         status;
  int                 mismatches;
  int                 pending;

  bit                 no_idle     = 1'b0;
  bit                 rx_hold_req = 1'b0;
  int                 chars_sent  = 0;
  logic [7:0]         script_q[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  rpn_expression_evaluator #(
    .STACK_DEPTH    (STACK_DEPTH),
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_char_i  (in_char),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .value_o    (value),
    .status_o   (status)
  );

  rpn_expression_evaluator_checker #(
    .STACK_DEPTH    (STACK_DEPTH),
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_char_i   (in_char),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .value_i     (value),
    .status_i    (status),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  function automatic bit is_token_char(input logic [7:0] c);
    return (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE) ||
           (c inside {rpn_pkg::CH_POINT, rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                      rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH, rpn_pkg::CH_HASH});
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return rpn_pkg::CH_PLUS;
      1:       return rpn_pkg::CH_MINUS;
      2:       return rpn_pkg::CH_STAR;
      default: return rpn_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic play_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic play_script();
    while (script_q.size() > 0) send_char(script_q.pop_front());
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic add_number(input int max_len);
    int         len, point_at, second_at;
    logic [7:0] digit;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 4);
    point_at = ($urandom_range(0, 9) < 3) ? $urandom_range(0, len - 1) : -1;
    second_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      digit = rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      script_q.push_back((i == point_at || i == second_at) ? rpn_pkg::CH_POINT : digit);
    end
  endtask

  task automatic add_separator();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      c = CH_SPACE;
    end else begin
      do c = 8'($urandom_range(0, 255)); while (is_token_char(c));
    end
    script_q.push_back(c);
  endtask

  // A well-formed expression: every operator finds two operands and one
  // value is left for the closing '#'. More than 32 values held at once overflow the stack.
  task automatic add_expression(input int operands, input int push_bias);
    int depth, pushes_left, ops_left;
    bit last_was_number;
    depth = 0;
    pushes_left = operands;
    ops_left = operands - 1;
    last_was_number = 1'b0;
    while (pushes_left > 0 || ops_left > 0) begin
      if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 99) < push_bias)) begin
        if (last_was_number || $urandom_range(0, 3) == 0) add_separator();
        add_number(MAX_TOKEN_CHARS - 1);
        depth++;
        pushes_left--;
        last_was_number = 1'b1;
      end else begin
        if ($urandom_range(0, 2) == 0) add_separator();
        script_q.push_back(random_op());
        depth--;
        ops_left--;
        last_was_number = 1'b0;
      end
    end
    if ($urandom_range(0, 1) == 1) add_separator();
    script_q.push_back(rpn_pkg::CH_HASH);
  endtask

  task automatic add_broken();
    case ($urandom_range(0, 3))
      0: begin
        add_number(4);
        script_q.push_back(random_op());
      end
      1: begin
        repeat ($urandom_range(MAX_TOKEN_CHARS, MAX_TOKEN_CHARS + 2)) begin
          script_q.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      2: begin
        add_number(5);
        add_separator();
        script_q.push_back(rpn_pkg::CH_ZERO);
        if ($urandom_range(0, 1) == 1) begin
          script_q.push_back(rpn_pkg::CH_POINT);
          script_q.push_back(rpn_pkg::CH_ZERO);
        end
        script_q.push_back(rpn_pkg::CH_SLASH);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 6)) script_q.push_back(8'($urandom_range(0, 255)));
    script_q.push_back(rpn_pkg::CH_HASH);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 12)) script_q.push_back(8'($urandom_range(0, 255)));
    script_q.push_back(rpn_pkg::CH_HASH);
  endtask

  task automatic build_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 66) add_expression($urandom_range(1, 6), 50);
    else if (kind < 74) add_expression($urandom_range(7, STACK_DEPTH), 85);
    else if (kind < 78) add_expression($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3), 100);
    else if (kind < 90) add_broken();
    else add_noise();
  endtask

  initial begin
    int span;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      span = idle_span();
      if (span > 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int random_start;
    bit hold_done, drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    play_text("#");
    play_text("3+4#");
    play_text("1.5 0.0/#");
    play_text("1234567890#");
    play_text("123456789 1.2.5-#");
    play_text("999999999 999999999*#");
    play_text("999999999 999999999+999999999+#");
    play_text("0 999999999-65536*#");
    play_text("2 3/.0000001 .5*-#");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_TAB);
    play_text("7 .#");
    repeat (STACK_DEPTH) play_text("1 ");
    play_text("9#");

    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      if (!hold_done && chars_sent - random_start > 250) begin
        hold_done = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (!drain_done && chars_sent - random_start > 600) begin
        drain_done = 1'b1;
        wait_for_drain();
      end
      no_idle = ($urandom_range(0, 4) == 0);
      build_sequence();
      play_script();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
